FILE: rtl/m2h_pkg.sv
// Shared types and constants for the streaming MurmurHash2 block.
// Used by the front end, the queue, the hash core and the top level.
package m2h_pkg;

   localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
   localparam int unsigned MIX_SHIFT   = 24;
   localparam int unsigned FIN_SHIFT_A = 13;
   localparam int unsigned FIN_SHIFT_B = 15;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        IDX_SEED   = 1'b0;

   typedef enum logic [1:0] {
      OP_FULL,
      OP_TAIL,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        use_init;
      logic        last;
      logic [31:0] word;
      logic [31:0] init;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      logic pop;
      logic busy;
   } core_stat_type;

endpackage

FILE: rtl/m2h_front.sv
// Front end: sorts each incoming item into a full word, a tail or nothing to mix.
// Masks the tail bytes and forms the starting hash. Depends on m2h_pkg.
module m2h_front (
   input  logic [31:0]       word,
   input  logic [2:0]        bytes_valid,
   input  logic              first,
   input  logic              last,
   input  logic [31:0]       total_length,
   input  logic [31:0]       seed,
   output m2h_pkg::entry_type entry
);

   logic [31:0] tail_mask;

   always_comb begin
      case (bytes_valid[1:0])
         2'd1:    tail_mask = 32'h0000_00ff;
         2'd2:    tail_mask = 32'h0000_ffff;
         2'd3:    tail_mask = 32'h00ff_ffff;
         default: tail_mask = 32'hffff_ffff;
      endcase
   end

   always_comb begin
      entry.use_init = first;
      entry.last     = last;
      entry.init     = seed ^ total_length;
      if (!last || bytes_valid >= 3'd4) begin
         entry.op   = m2h_pkg::OP_FULL;
         entry.word = word;
      end else if (bytes_valid == 3'd0) begin
         entry.op   = m2h_pkg::OP_NONE;
         entry.word = word;
      end else begin
         entry.op   = m2h_pkg::OP_TAIL;
         entry.word = word & tail_mask;
      end
   end

endmodule

FILE: rtl/m2h_queue.sv
// Short first-in first-out queue of sorted items between front end and core.
// Depends on m2h_pkg for the entry and status types.
module m2h_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  m2h_pkg::entry_type   push_entry,
   input  logic                 pop,
   output m2h_pkg::entry_type   head,
   output m2h_pkg::q_stat_type  stat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   m2h_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push;
   logic               do_pop;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/m2h_core.sv
// Hash core: mixes queued items into the running hash with one shared multiplier.
// Applies the final avalanche and holds the digest. Depends on m2h_pkg.
module m2h_core (
   input  logic                  clock,
   input  logic                  reset,
   input  m2h_pkg::entry_type    head,
   input  m2h_pkg::q_stat_type   q_stat,
   output m2h_pkg::core_stat_type stat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [31:0]           rsp_digest
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY1,
      ST_KEY2,
      ST_HMUL,
      ST_TAIL,
      ST_FIN,
      ST_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] run_ff, run_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] k_ff, k_in;
   logic        last_ff, last_in;
   logic        valid_ff, valid_in;
   logic [31:0] digest_ff, digest_in;
   logic [31:0] mul_a;
   logic [31:0] mul_p;

   assign stat.busy  = (state_ff != ST_IDLE);
   assign stat.pop   = (state_ff == ST_IDLE) && !q_stat.empty;
   assign rsp_valid  = valid_ff;
   assign rsp_digest = digest_ff;

   always_comb begin
      case (state_ff)
         ST_KEY1: mul_a = k_ff;
         ST_KEY2: mul_a = k_ff ^ (k_ff >> m2h_pkg::MIX_SHIFT);
         ST_HMUL: mul_a = acc_ff;
         ST_TAIL: mul_a = acc_ff ^ k_ff;
         ST_FIN:  mul_a = acc_ff ^ (acc_ff >> m2h_pkg::FIN_SHIFT_A);
         default: mul_a = '0;
      endcase
   end

   assign mul_p = 32'(mul_a * m2h_pkg::MIX_MUL);

   always_comb begin
      state_in  = state_ff;
      run_in    = run_ff;
      acc_in    = acc_ff;
      k_in      = k_ff;
      last_in   = last_ff;
      valid_in  = valid_ff && rsp_stall;
      digest_in = digest_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               acc_in  = head.use_init ? head.init : run_ff;
               k_in    = head.word;
               last_in = head.last;
               case (head.op)
                  m2h_pkg::OP_FULL: state_in = ST_KEY1;
                  m2h_pkg::OP_TAIL: state_in = ST_TAIL;
                  default: begin
                     run_in   = acc_in;
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_KEY1: begin
            k_in     = mul_p;
            state_in = ST_KEY2;
         end
         ST_KEY2: begin
            k_in     = mul_p;
            state_in = ST_HMUL;
         end
         ST_HMUL: begin
            acc_in   = mul_p ^ k_ff;
            run_in   = acc_in;
            state_in = last_ff ? ST_FIN : ST_IDLE;
         end
         ST_TAIL: begin
            acc_in   = mul_p;
            run_in   = acc_in;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            acc_in   = mul_p;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!valid_ff || !rsp_stall) begin
               digest_in = acc_ff ^ (acc_ff >> m2h_pkg::FIN_SHIFT_B);
               valid_in  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      k_ff      <= k_in;
      last_ff   <= last_in;
      digest_ff <= digest_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         run_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         run_ff   <= run_in;
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: rtl/murmur2_hash32.sv
// Top level of the streaming 32-bit MurmurHash2 block with its seed register.
// Instantiates m2h_front, m2h_queue and m2h_core; depends on m2h_pkg.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  word, bytes_valid, first, last, total_length
//   rsp       out        rsp_valid/rsp_stall  digest
//   csr       in/out     APB, pready high     seed at byte address 0
//
// A full word takes the core states KEY1, KEY2 and HMUL, a last one also FIN and OUT;
// a last tail TAIL, FIN and OUT, a last empty word FIN and OUT; all share one multiplier.
// The queue takes items while the core works, up to QUEUE_DEPTH of them.
// Synchronous reset clears the queue, the core state, the running hash and the seed.
// A stalled digest holds in the output register; the core waits on it only
// when it has the next digest ready.
module murmur2_hash32 #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [31:0]                     req_word,
   input  logic [2:0]                      req_bytes_valid,
   input  logic                            req_first,
   input  logic                            req_last,
   input  logic [31:0]                     req_total_length,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [31:0]                     rsp_digest,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [m2h_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic [31:0]            seed_ff;
   logic                   seed_wr;
   logic                   push;
   m2h_pkg::entry_type     front_entry;
   m2h_pkg::entry_type     head;
   m2h_pkg::q_stat_type    q_stat;
   m2h_pkg::core_stat_type core_stat;

   assign csr_pready = 1'b1;
   assign seed_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == m2h_pkg::IDX_SEED);
   assign csr_prdata = (csr_paddr[2] == m2h_pkg::IDX_SEED) ? seed_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (seed_wr) begin
         seed_ff <= csr_pwdata;
      end
   end

   assign req_stall = q_stat.full;
   assign push      = req_valid && !req_stall;

   m2h_front u_front (
      .word         (req_word),
      .bytes_valid  (req_bytes_valid),
      .first        (req_first),
      .last         (req_last),
      .total_length (req_total_length),
      .seed         (seed_ff),
      .entry        (front_entry)
   );

   m2h_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (core_stat.pop),
      .head       (head),
      .stat       (q_stat)
   );

   m2h_core u_core (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_stat     (q_stat),
      .stat       (core_stat),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_digest (rsp_digest)
   );

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      core_stat.pop |-> !q_stat.empty)
      else $error("core popped an empty queue");

   a_digest_from_core: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(core_stat.busy))
      else $error("digest appeared without core activity");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (q_stat.empty && !rsp_valid && !core_stat.busy))
      else $error("reset left queue or core occupied");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for murmur2_hash32, the streaming MurmurHash2 block.
// Depends on m2h_pkg and the block's RTL; it predicts every digest and compares it.
`timescale 1ns / 1ps

module testbench;

   localparam logic [31:0] HASH_MUL   = 32'h5bd1e995;
   localparam int          KEY_SHIFT  = 24;
   localparam int          FOLD_SHIFT = 13;
   localparam int          LAST_SHIFT = 15;
   localparam logic [m2h_pkg::CSR_ADDR_W-1:0] SEED_ADDR = {m2h_pkg::IDX_SEED, 2'b00};
   localparam int          SETTLE_CYCLES = 24;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          PHASE_ITEMS   = 132;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [31:0]                     req_word;
   logic [2:0]                      req_bytes_valid;
   logic                            req_first;
   logic                            req_last;
   logic [31:0]                     req_total_length;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [31:0]                     rsp_digest;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [m2h_pkg::CSR_ADDR_W-1:0]  csr_paddr;
   logic [31:0]                     csr_pwdata;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   logic [31:0] seed_value;
   logic [31:0] hash_state;
   logic [31:0] expected_digests[$];
   logic [31:0] wanted_digest;
   int          idle_pct;
   int          stall_pct;
   int          error_count;
   int          items_sent;
   int          digests_checked;
   int          seed_writes;
   int          cycle_count;

   murmur2_hash32 u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .req_bytes_valid  (req_bytes_valid),
      .req_first        (req_first),
      .req_last         (req_last),
      .req_total_length (req_total_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digest       (rsp_digest),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_digests.size() == 0) begin
            $error("digest: expected none, actual %08h", rsp_digest);
            error_count++;
         end else begin
            wanted_digest = expected_digests.pop_front();
            digests_checked++;
            if (rsp_digest !== wanted_digest) begin
               $error("digest: expected %08h, actual %08h", wanted_digest, rsp_digest);
               error_count++;
            end
         end
      end
   end

   // Advances the running hash by one accepted item and queues the digest on a last item.
   function automatic void murmur_absorb(input logic [31:0] word, input logic [2:0] nbytes,
                                         input logic is_first, input logic is_last,
                                         input logic [31:0] total);
      logic [31:0] h;
      logic [31:0] k;
      logic [31:0] mask;
      int unsigned count;
      h = is_first ? (seed_value ^ total) : hash_state;
      count = (nbytes > 4) ? 4 : nbytes;
      if (!is_last || count == 4) begin
         k = word * HASH_MUL;
         k = k ^ (k >> KEY_SHIFT);
         k = k * HASH_MUL;
         h = (h * HASH_MUL) ^ k;
      end else if (count != 0) begin
         mask = 32'hffffffff >> (8 * (4 - count));
         h = (h ^ (word & mask)) * HASH_MUL;
      end
      hash_state = h;
      if (is_last) begin
         h = h ^ (h >> FOLD_SHIFT);
         h = h * HASH_MUL;
         h = h ^ (h >> LAST_SHIFT);
         expected_digests.push_back(h);
      end
   endfunction

   task automatic send_request(input logic [31:0] word, input logic [2:0] nbytes,
                               input logic is_first, input logic is_last,
                               input logic [31:0] total);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_word         <= word;
      req_bytes_valid  <= nbytes;
      req_first        <= is_first;
      req_last         <= is_last;
      req_total_length <= total;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      murmur_absorb(word, nbytes, is_first, is_last, total);
      items_sent++;
   endtask

   task automatic wait_for_digests;
      while (expected_digests.size() != 0) @(posedge clock);
   endtask

   task automatic csr_access(input logic is_write, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= SEED_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // The block must be idle, so the sender stops and any hash in progress is let finish.
   task automatic write_seed(input logic [31:0] value);
      logic [31:0] readback;
      req_valid <= 1'b0;
      wait_for_digests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_access(1'b1, value, readback);
      seed_value = value;
      seed_writes++;
      csr_access(1'b0, 32'h0, readback);
      if (readback !== value) begin
         $error("seed: expected %08h, actual %08h", value, readback);
         error_count++;
      end
   endtask

   task automatic send_message(input int length, input logic [31:0] total,
                               input logic is_first);
      int full_words;
      int tail;
      int count;
      logic is_last;
      full_words = length / 4;
      tail       = length % 4;
      count      = (tail != 0 || length == 0) ? full_words + 1 : full_words;
      for (int i = 0; i < count; i++) begin
         is_last = (i == count - 1);
         send_request($urandom, (is_last && i == full_words) ? 3'(tail) : 3'd4,
                      is_first && i == 0, is_last, total);
      end
   endtask

   task automatic test_single_item_messages;
      write_seed(32'h0);
      send_request(32'hffffffff, 3'd0, 1'b1, 1'b1, 32'h0);
      for (int n = 1; n <= 3; n++) send_request(32'hffffffff, 3'(n), 1'b1, 1'b1, 32'(n));
      send_request(32'h00000000, 3'd4, 1'b1, 1'b1, 32'd4);
      send_request(32'hffffffff, 3'd4, 1'b1, 1'b1, 32'd4);
      for (int n = 5; n <= 7; n++) send_request(32'ha5a5a5a5, 3'(n), 1'b1, 1'b1, 32'hffffffff);
   endtask

   task automatic test_multi_item_messages;
      write_seed(32'hffffffff);
      send_request(32'h01234567, 3'd4, 1'b1, 1'b0, 32'd7);
      send_request(32'hffffffff, 3'd3, 1'b0, 1'b1, 32'h0);
      send_request(32'h5a5a5a5a, 3'd0, 1'b1, 1'b0, 32'd12);
      send_request(32'h80000001, 3'd2, 1'b0, 1'b0, 32'hffffffff);
      send_request(32'hdeadbeef, 3'd4, 1'b0, 1'b1, 32'h0);
   endtask

   task automatic test_irregular_framing;
      write_seed(32'h9747b28c);
      send_request(32'h12345678, 3'd4, 1'b0, 1'b1, 32'h0);
      send_request(32'hcafef00d, 3'd1, 1'b0, 1'b0, 32'h0);
      send_request(32'h0f0f0f0f, 3'd4, 1'b1, 1'b0, 32'h0);
      send_request(32'hffffffff, 3'd0, 1'b0, 1'b1, 32'h0);
      send_request(32'h00ffff00, 3'd3, 1'b1, 1'b1, 32'hffffffff);
   endtask

   // Mostly well-formed messages of random content; the rest are single items of any shape.
   task automatic test_random_traffic(input int gap_pct, input int hold_pct,
                                      input logic [31:0] seed);
      int target;
      int length;
      bit paused;
      write_seed(seed);
      idle_pct  = gap_pct;
      stall_pct = hold_pct;
      target    = items_sent + PHASE_ITEMS;
      paused    = 1'b0;
      while (items_sent < target) begin
         if (!paused && items_sent > target - PHASE_ITEMS / 2) begin
            req_valid <= 1'b0;
            wait_for_digests();
            paused = 1'b1;
         end
         if ($urandom_range(99) < 80) begin
            length = ($urandom_range(99) < 5) ? $urandom_range(25, 64) : $urandom_range(0, 24);
            send_message(length, ($urandom_range(9) == 0) ? $urandom : 32'(length), 1'b1);
         end else begin
            send_request($urandom, 3'($urandom_range(7)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), $urandom);
         end
      end
      idle_pct  = 0;
      stall_pct = 0;
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_word         <= 32'h0;
      req_bytes_valid  <= 3'd0;
      req_first        <= 1'b0;
      req_last         <= 1'b0;
      req_total_length <= 32'h0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= 32'h0;
      seed_value      = 32'h0;
      hash_state      = 32'h0;
      idle_pct        = 0;
      stall_pct       = 0;
      error_count     = 0;
      items_sent      = 0;
      digests_checked = 0;
      seed_writes     = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_single_item_messages();
      test_multi_item_messages();
      test_irregular_framing();
      test_random_traffic(0, 0, 32'hffffffff);
      test_random_traffic(83, 0, $urandom);
      test_random_traffic(0, 83, 32'h80000000);
      test_random_traffic(36, 36, $urandom);

      req_valid <= 1'b0;
      wait_for_digests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d items under %0d seed settings and checked %0d digests,",
               items_sent, seed_writes, digests_checked);
      $display("with sender gaps and receiver stalls applied alone, together and not at all.");
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
